// ===== design/ordered_list_engine_macros.svh =====
// Assertion macros shared by the ordered list engine modules.
// No dependencies; include by bare file name where assertions are written.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define OLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ole_pkg.sv =====
// Shared constants, codes and control structs of the ordered list engine.
// No dependencies; imported by the controller, datapath and top level.
package ole_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int FUNC_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int CELL_OP_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DUMP_FWD = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DUMP_REV = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 3'd0;
  localparam logic [CELL_OP_W-1:0] CELL_INSERT = 3'd1;
  localparam logic [CELL_OP_W-1:0] CELL_DELETE = 3'd2;
  localparam logic [CELL_OP_W-1:0] CELL_ROT_L  = 3'd3;
  localparam logic [CELL_OP_W-1:0] CELL_ROT_R  = 3'd4;

  typedef struct packed {
    logic [CELL_OP_W-1:0] cell_op;
    logic                 out_load;
    logic                 out_dump;
    logic                 out_use_match;
    logic [STATUS_W-1:0]  out_status;
    logic [POS_W-1:0]     out_pos;
    logic                 out_last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic found;
    logic out_free;
  } sts_t;

endpackage

// ===== design/ole_dpath.sv =====
// Datapath of the ordered list engine: ring of entry cells, entry count and
// result register. Depends on ole_pkg and ordered_list_engine_macros.svh.
`include "ordered_list_engine_macros.svh"

module ole_dpath import ole_pkg::*; #(
  parameter int  CAPACITY = CAPACITY_DEF,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int IW       = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  output logic [CW-1:0]              count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [POS_W-1:0]           out_position,
  output logic signed [VALUE_W-1:0]  out_data_out,
  output logic                       out_last
);

  logic [VALUE_W-1:0]  cells_r   [CAPACITY];
  logic [VALUE_W-1:0]  cells_nxt [CAPACITY];
  logic [CW-1:0]       count_r, count_nxt;
  logic [CAPACITY-1:0] match, seen, first;
  logic [IW-1:0]       match_pos;
  logic [VALUE_W-1:0]  tap;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [VALUE_W-1:0]  out_data_r;
  logic                out_last_r;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < count_r) && (cells_r[i] == in_value);
    end
    seen[0]  = match[0];
    first[0] = match[0];
    for (int i = 1; i < CAPACITY; i++) begin
      seen[i]  = seen[i-1] | match[i];
      first[i] = match[i] & ~seen[i-1];
    end
    match_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_pos = match_pos | (first[i] ? IW'(i) : '0);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    count_nxt = count_r;
    case (cmd.cell_op)
      CELL_INSERT: begin
        cells_nxt[0] = in_value;
        for (int i = 1; i < CAPACITY; i++) begin
          cells_nxt[i] = cells_r[i-1];
        end
        count_nxt = count_r + CW'(1);
      end
      CELL_DELETE: begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (seen[i]) begin
            cells_nxt[i] = cells_r[i+1];
          end
        end
        count_nxt = count_r - CW'(1);
      end
      CELL_ROT_L: begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          cells_nxt[i] = cells_r[i+1];
        end
        cells_nxt[CAPACITY-1] = cells_r[0];
      end
      CELL_ROT_R: begin
        cells_nxt[0] = cells_r[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++) begin
          cells_nxt[i] = cells_r[i-1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign tap = (cmd.cell_op == CELL_ROT_R) ? cells_r[CAPACITY-1] : cells_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_pos_r    <= cmd.out_use_match ? POS_W'(match_pos) : cmd.out_pos;
      out_data_r   <= cmd.out_dump ? tap : in_value;
      out_last_r   <= cmd.out_last;
    end
  end

  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CW'(CAPACITY));
  assign sts.found    = |match;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign count        = count_r;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

  `OLE_ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.cell_op == CELL_INSERT,
                   count_r == $past(count_r) + CW'(1), "insert did not grow the list")
  `OLE_ASSERT_NEXT(a_delete_shrinks, clk, rst_n, cmd.cell_op == CELL_DELETE,
                   count_r == $past(count_r) - CW'(1), "delete did not shrink the list")
  `OLE_ASSERT_NOW(a_load_free, clk, rst_n, cmd.out_load,
                  !out_valid_r || !out_stall, "result overwrites a pending transfer")

endmodule

// ===== design/ole_ctrl.sv =====
// Controller of the ordered list engine: decodes operations and sequences
// the dump ring rotation. Depends on ole_pkg and ordered_list_engine_macros.svh.
`include "ordered_list_engine_macros.svh"

module ole_ctrl import ole_pkg::*; #(
  parameter int  CAPACITY = CAPACITY_DEF,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int IW       = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  sts_t              sts,
  input  logic [CW-1:0]     count,
  output cmd_t              cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic          state_r, state_nxt;
  logic          rev_r, rev_nxt;
  logic [IW-1:0] step_r, step_nxt;

  logic          accept;
  logic [CW:0]   rev_sum;
  logic          emit, last_step, dump_last, advance;
  logic [IW-1:0] dump_pos;

  assign in_stall  = !((state_r == S_IDLE) && sts.out_free);
  assign accept    = in_valid && !in_stall;
  assign rev_sum   = (CW+1)'(step_r) + (CW+1)'(count);
  assign emit      = rev_r ? (rev_sum >= (CW+1)'(CAPACITY)) : (CW'(step_r) < count);
  assign last_step = (step_r == IW'(CAPACITY - 1));
  assign dump_pos  = rev_r ? (IW'(CAPACITY - 1) - step_r) : step_r;
  assign dump_last = rev_r ? last_step : ((CW'(step_r) + CW'(1)) == count);
  assign advance   = !emit || sts.out_free;

  always_comb begin
    cmd            = '0;
    cmd.cell_op    = CELL_HOLD;
    cmd.out_status = ST_OK;
    state_nxt      = state_r;
    rev_nxt        = rev_r;
    step_nxt       = step_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_INSERT: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (sts.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.cell_op = CELL_INSERT;
              end
            end
            FUNC_DELETE, FUNC_SEARCH: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (sts.empty) begin
                cmd.out_status = ST_EMPTY;
              end else if (!sts.found) begin
                cmd.out_status = ST_NOTFOUND;
              end else begin
                cmd.out_use_match = 1'b1;
                if (in_func == FUNC_DELETE) begin
                  cmd.cell_op = CELL_DELETE;
                end
              end
            end
            FUNC_DUMP_FWD, FUNC_DUMP_REV: begin
              if (sts.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                state_nxt = S_DUMP;
                rev_nxt   = (in_func == FUNC_DUMP_REV);
                step_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (advance) begin
          cmd.cell_op  = rev_r ? CELL_ROT_R : CELL_ROT_L;
          cmd.out_load = emit;
          cmd.out_dump = 1'b1;
          cmd.out_pos  = POS_W'(dump_pos);
          cmd.out_last = emit && dump_last;
          step_nxt     = step_r + IW'(1);
          if (last_step) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rev_r   <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rev_r   <= rev_nxt;
      step_r  <= step_nxt;
    end
  end

  `OLE_ASSERT_NOW(a_no_insert_full, clk, rst_n, cmd.cell_op == CELL_INSERT, !sts.full, "insert issued on a full list")
  `OLE_ASSERT_NOW(a_dump_nonempty, clk, rst_n, (state_r == S_IDLE) && (state_nxt == S_DUMP), !sts.empty, "dump sequence started on an empty list")
  `OLE_ASSERT_NOW(a_dump_rotates, clk, rst_n, (state_r == S_DUMP) && cmd.out_load, cmd.out_dump && ((cmd.cell_op == CELL_ROT_L) || (cmd.cell_op == CELL_ROT_R)), "dump result without ring rotation")

endmodule

// ===== design/ordered_list_engine.sv =====
// Top level of the ordered list engine: controller plus cell-ring datapath.
// Depends on ole_pkg, ole_ctrl and ole_dpath.
//
// Bounded list of signed 32-bit entries kept in a ring of CAPACITY cells.
// Insert, delete and search compare or shift all cells at once: the item is
// accepted and its single result is registered at the same edge, so a new
// item can follow every cycle while the result slot drains. A dump of a
// non-empty list rotates the whole ring once, one cell per cycle unless the
// result side stalls, emitting at a tap fixed per direction; the input is
// stalled until it ends. Operation codes 5 to 7 are dropped with no result.

module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [POS_W-1:0]           out_position,
  output logic signed [VALUE_W-1:0]  out_data_out,
  output logic                       out_last
);

  localparam int CW = $clog2(CAPACITY + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] count;

  ole_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .sts      (sts),
    .count    (count),
    .cmd      (cmd)
  );

  ole_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .cmd          (cmd),
    .sts          (sts),
    .count        (count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_position (out_position),
    .out_data_out (out_data_out),
    .out_last     (out_last)
  );

endmodule
